// ===== hdl/modified_xxtea_block_cipher_assert.svh =====
// Assertion macros for the modified XXTEA block cipher.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MODIFIED_XXTEA_BLOCK_CIPHER_ASSERT_SVH
`define MODIFIED_XXTEA_BLOCK_CIPHER_ASSERT_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define MXT_ASSERT_HOLD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define MXT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MXT_ASSERT_HOLD(lbl, clk, rst, prop, msg)
`define MXT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/mxt_pkg.sv =====
// Shared constants, types and codes of the modified XXTEA block cipher.
// No dependencies; imported by every module of the block.
`default_nettype none

package mxt_pkg;

   // block geometry
   localparam int MAX_WORDS  = 64;
   localparam int WORD_W     = 32;
   localparam int ADDR_W     = $clog2(MAX_WORDS);
   localparam int CNT_W      = $clog2(MAX_WORDS + 1);

   // round schedule: (ROUND_BASE + ROUND_NUM / n) * n rounds
   localparam int ROUND_BASE = 6;
   localparam int ROUND_NUM  = 52;
   localparam int ROUNDS_W   = $clog2(ROUND_BASE * MAX_WORDS + ROUND_NUM + 1);
   localparam int QUOT_W     = $clog2(ROUND_NUM / 2 + 1);
   localparam int REM_W      = $clog2(ROUND_NUM + 1);
   localparam int DIV_W      = (REM_W > CNT_W) ? REM_W : CNT_W;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

   // configuration register map
   localparam int KEY_WORDS = 4;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY0,
      CSR_KEY1,
      CSR_KEY2,
      CSR_KEY3,
      CSR_MODE
   } csr_index_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_PRE_A,
      ST_PRE_B,
      ST_PRE_C,
      ST_RUN,
      ST_DRAIN,
      ST_OUT
   } seq_state_type;

   // sequencer to datapath control
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              load_we;
      logic              step;
      logic [ADDR_W-1:0] wr_addr;
      logic              decrypt;
      logic              load_other;
      logic              load_cur;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] key;
   } dp_ctrl_type;

   // memory write request
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } ram_wr_type;

endpackage

`default_nettype wire

// ===== hdl/mxt_word_ram.sv =====
// Word store of the block: one write port, one registered read port.
// Depends on mxt_pkg for geometry and the write request type.
`default_nettype none

module mxt_word_ram (
   input  logic                      clock,
   input  mxt_pkg::ram_wr_type       wr,
   input  logic                      rd_en,
   input  logic [mxt_pkg::ADDR_W-1:0] rd_addr,
   output logic [mxt_pkg::WORD_W-1:0] rd_data
);
   import mxt_pkg::*;

   logic [WORD_W-1:0] word_store_ff [MAX_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         word_store_ff[wr.addr] <= wr.data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= word_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/mxt_datapath.sv =====
// Word update datapath: mixing function, add or subtract, read forwarding.
// Depends on mxt_pkg; fed by mxt_seq and mxt_word_ram.
`default_nettype none

module mxt_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  mxt_pkg::dp_ctrl_type       ctrl,
   input  logic [mxt_pkg::WORD_W-1:0] load_data,
   input  logic [mxt_pkg::WORD_W-1:0] rd_data,
   output mxt_pkg::ram_wr_type        wr
);
   import mxt_pkg::*;

   logic [WORD_W-1:0] cur_ff, cur_in;
   logic [WORD_W-1:0] other_ff, other_in;
   logic [WORD_W-1:0] fwd_data_ff, fwd_data_in;
   logic              fwd_ff, fwd_in;
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] mix_y;
   logic [WORD_W-1:0] mix_z;
   logic [WORD_W-1:0] mix_out;
   logic [WORD_W-1:0] new_word;

   // modified mixing function, shifts 7/3/5/6
   function automatic logic [WORD_W-1:0] mix(
      input logic [WORD_W-1:0] y,
      input logic [WORD_W-1:0] z,
      input logic [WORD_W-1:0] sum,
      input logic [WORD_W-1:0] k
   );
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      a = (z >> 7) ^ (y << 3);
      b = (y >> 5) ^ (z << 6);
      c = (sum ^ y) + (k ^ z);
      return (a + b) ^ c;
   endfunction

   // read data, replaced by the word written in the cycle of the read
   assign rd_word = fwd_ff ? fwd_data_ff : rd_data;

   // encrypt reads the right neighbor (y), decrypt the left one (z)
   assign mix_y    = ctrl.decrypt ? other_ff : rd_word;
   assign mix_z    = ctrl.decrypt ? rd_word : other_ff;
   assign mix_out  = mix(mix_y, mix_z, ctrl.sum, ctrl.key);
   assign new_word = ctrl.decrypt ? cur_ff - mix_out : cur_ff + mix_out;

   // memory write: loaded request word or updated word
   always_comb begin
      wr.we   = ctrl.load_we | ctrl.step;
      wr.addr = ctrl.wr_addr;
      wr.data = ctrl.load_we ? load_data : new_word;
   end

   // operand registers and forwarding
   always_comb begin
      cur_in      = cur_ff;
      other_in    = other_ff;
      fwd_in      = ctrl.rd_en && wr.we && (wr.addr == ctrl.rd_addr);
      fwd_data_in = wr.data;
      if (ctrl.load_other) begin
         other_in = rd_word;
      end
      if (ctrl.load_cur) begin
         cur_in = rd_word;
      end
      if (ctrl.step) begin
         other_in = new_word;
         cur_in   = rd_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
      cur_ff      <= cur_in;
      other_ff    <= other_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/mxt_seq.sv =====
// Sequencer: word loading, round count setup, round/word stepping, result readout.
// Depends on mxt_pkg and the assertion macro header.
`default_nettype none
`include "modified_xxtea_block_cipher_assert.svh"

module mxt_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       last_word,
   input  logic                       decrypt_mode,
   input  mxt_pkg::key_type           key,
   output logic                       busy,
   output mxt_pkg::dp_ctrl_type       ctrl,
   output logic                       rsp_valid,
   output logic                       rsp_last,
   output logic                       rsp_over
);
   import mxt_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                over_ff, over_in;
   logic                mode_ff, mode_in;
   logic [REM_W-1:0]    div_rem_ff, div_rem_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [ROUNDS_W-1:0] rounds_ff, rounds_in;
   logic [ROUNDS_W-1:0] rem_ff, rem_in;
   logic [1:0]          kr_ff, kr_in;
   logic [ADDR_W-1:0]   q_ff, q_in;
   logic [WORD_W-1:0]   sum_ff, sum_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]   s1_waddr_ff, s1_waddr_in;
   logic [WORD_W-1:0]   s1_sum_ff, s1_sum_in;
   logic [WORD_W-1:0]   s1_key_ff, s1_key_in;
   logic [ADDR_W-1:0]   out_addr_ff, out_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_over_ff, rsp_over_in;

   logic                  accept;
   logic                  room;
   logic [CNT_W-1:0]      cnt_next;
   logic [CNT_W-1:0]      count_less;
   logic [ADDR_W-1:0]     last_addr;
   logic [DIV_W-1:0]      div_num;
   logic [DIV_W-1:0]      div_den;
   logic [DIV_W-1:0]      div_diff;
   logic [QUOT_W:0]       factor;
   logic [QUOT_W+CNT_W:0] rounds_prod;
   logic [ROUNDS_W+WORD_W-1:0] sum_prod;
   logic                  enc_end;
   logic                  dec_end;
   logic                  round_end;
   logic [ADDR_W-1:0]     issue_addr;
   logic [WORD_W-1:0]     issue_key;

   // block size helpers
   assign accept     = start && (state_ff == ST_IDLE);
   assign room       = count_ff < CNT_W'(MAX_WORDS);
   assign cnt_next   = room ? count_ff + CNT_W'(1) : count_ff;
   assign count_less = count_ff - CNT_W'(1);
   assign last_addr  = count_less[ADDR_W-1:0];

   // round count setup arithmetic
   assign div_num     = DIV_W'(div_rem_ff);
   assign div_den     = DIV_W'(count_ff);
   assign div_diff    = div_num - div_den;
   assign factor      = (QUOT_W + 1)'(ROUND_BASE) + (QUOT_W + 1)'(quot_ff);
   assign rounds_prod = (QUOT_W + CNT_W + 1)'(factor) * (QUOT_W + CNT_W + 1)'(count_ff);
   assign sum_prod    = (ROUNDS_W + WORD_W)'(rounds_ff) * (ROUNDS_W + WORD_W)'(TEA_DELTA);

   // word step issue: next address is also the next word index
   assign enc_end    = (q_ff == last_addr);
   assign dec_end    = (q_ff == '0);
   assign round_end  = mode_ff ? dec_end : enc_end;
   assign issue_addr = mode_ff ? (dec_end ? last_addr : q_ff - ADDR_W'(1))
                               : (enc_end ? '0 : q_ff + ADDR_W'(1));
   assign issue_key  = key[kr_ff ^ sum_ff[3:2]];

   // next state and control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      over_in     = over_ff;
      mode_in     = mode_ff;
      div_rem_in  = div_rem_ff;
      quot_in     = quot_ff;
      rounds_in   = rounds_ff;
      rem_in      = rem_ff;
      kr_in       = kr_ff;
      q_in        = q_ff;
      sum_in      = sum_ff;
      s1_valid_in = 1'b0;
      s1_waddr_in = s1_waddr_ff;
      s1_sum_in   = s1_sum_ff;
      s1_key_in   = s1_key_ff;
      out_addr_in = out_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = rsp_last_ff;
      rsp_over_in  = rsp_over_ff;

      ctrl.rd_en      = 1'b0;
      ctrl.rd_addr    = issue_addr;
      ctrl.load_we    = 1'b0;
      ctrl.step       = s1_valid_ff;
      ctrl.wr_addr    = s1_valid_ff ? s1_waddr_ff : count_ff[ADDR_W-1:0];
      ctrl.decrypt    = mode_ff;
      ctrl.load_other = 1'b0;
      ctrl.load_cur   = 1'b0;
      ctrl.sum        = s1_sum_ff;
      ctrl.key        = s1_key_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.load_we = room;
               over_in      = over_ff | ~room;
               count_in     = cnt_next;
               mode_in      = decrypt_mode;
               if (last_word) begin
                  if (cnt_next >= CNT_W'(2)) begin
                     state_in   = ST_DIV;
                     div_rem_in = REM_W'(ROUND_NUM);
                     quot_in    = '0;
                  end else begin
                     state_in    = ST_OUT;
                     out_addr_in = '0;
                  end
               end
            end
         end
         // quotient of the round constant by the block size, one subtract a cycle
         ST_DIV: begin
            if (div_num >= div_den) begin
               div_rem_in = div_diff[REM_W-1:0];
               quot_in    = quot_ff + QUOT_W'(1);
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rounds_in = rounds_prod[ROUNDS_W-1:0];
            state_in  = ST_SUM;
         end
         // initial sum, round counters and word index
         ST_SUM: begin
            sum_in   = mode_ff ? sum_prod[WORD_W-1:0] : TEA_DELTA;
            rem_in   = rounds_ff;
            kr_in    = mode_ff ? rounds_ff[1:0] - 2'd1 : 2'd0;
            q_in     = mode_ff ? last_addr : '0;
            state_in = ST_PRE_A;
         end
         // fetch the neighbor word of the first step
         ST_PRE_A: begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = mode_ff ? '0 : last_addr;
            state_in     = ST_PRE_B;
         end
         // fetch the first word to update
         ST_PRE_B: begin
            ctrl.rd_en      = 1'b1;
            ctrl.rd_addr    = mode_ff ? last_addr : '0;
            ctrl.load_other = 1'b1;
            state_in        = ST_PRE_C;
         end
         ST_PRE_C, ST_RUN: begin
            ctrl.load_cur = (state_ff == ST_PRE_C);
            ctrl.rd_en    = 1'b1;
            ctrl.rd_addr  = issue_addr;
            s1_valid_in   = 1'b1;
            s1_waddr_in   = q_ff;
            s1_sum_in     = sum_ff;
            s1_key_in     = issue_key;
            q_in          = issue_addr;
            state_in      = ST_RUN;
            if (round_end) begin
               rem_in = rem_ff - ROUNDS_W'(1);
               kr_in  = mode_ff ? kr_ff - 2'd1 : kr_ff + 2'd1;
               sum_in = mode_ff ? sum_ff - TEA_DELTA : sum_ff + TEA_DELTA;
               if (rem_ff == ROUNDS_W'(1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            out_addr_in = '0;
            state_in    = ST_OUT;
         end
         // read out one word a cycle
         ST_OUT: begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = out_addr_ff;
            rsp_valid_in = 1'b1;
            rsp_last_in  = (out_addr_ff == last_addr);
            rsp_over_in  = over_ff;
            out_addr_in  = out_addr_ff + ADDR_W'(1);
            if (out_addr_ff == last_addr) begin
               state_in = ST_IDLE;
               count_in = '0;
               over_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         over_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         over_ff      <= over_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      div_rem_ff  <= div_rem_in;
      quot_ff     <= quot_in;
      rounds_ff   <= rounds_in;
      rem_ff      <= rem_in;
      kr_ff       <= kr_in;
      q_ff        <= q_in;
      sum_ff      <= sum_in;
      s1_waddr_ff <= s1_waddr_in;
      s1_sum_ff   <= s1_sum_in;
      s1_key_ff   <= s1_key_in;
      out_addr_ff <= out_addr_in;
      rsp_last_ff <= rsp_last_in;
      rsp_over_ff <= rsp_over_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_over  = rsp_over_ff;

   // checks
   `MXT_ASSERT_HOLD(a_step_in_run, clock, reset, !s1_valid_ff || state_ff == ST_RUN || state_ff == ST_DRAIN, "word update outside the cipher phase")
   `MXT_ASSERT_HOLD(a_rounds_left, clock, reset, state_ff != ST_RUN || rem_ff != '0, "cipher running with no rounds left")
   `MXT_ASSERT_NEXT(a_out_strobe, clock, reset, state_ff == ST_OUT, rsp_valid_ff, "readout cycle without a result strobe")
   `MXT_ASSERT_NEXT(a_block_done, clock, reset, state_ff == ST_OUT && out_addr_ff == last_addr, state_ff == ST_IDLE && count_ff == '0 && !over_ff, "block state not cleared after readout")

endmodule

`default_nettype wire

// ===== hdl/modified_xxtea_block_cipher.sv =====
// Top level of the modified XXTEA block cipher: configuration registers and wiring.
// Depends on mxt_pkg, mxt_word_ram, mxt_datapath and mxt_seq.
//
// Words of a block are taken one per cycle while busy is low (start high), the
// final one marked by req_last_word; up to 64 words are kept and further words
// are dropped and reported through rsp_too_long. After the final word the block
// is encrypted or decrypted in place, as decrypt_mode stood at that word. Setup
// divides 52 by n for n words and forms the round count; the cipher then runs
// (6 + 52/n) * n rounds of n word updates, one word per cycle, after two
// fetches of the first operands and before a drain. A block of one word skips
// the cipher. The n results then follow on consecutive cycles, each shown for
// one cycle with rsp_strobe; the receiver cannot stall them and must take each
// one as it comes. busy stays high from the final word until the last result is
// being read, and a new block may start in the cycle that last result is shown.
// Key and mode must be written only while idle; the block does not enforce it.
`default_nettype none

module modified_xxtea_block_cipher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [31:0]                   req_data_word,
   input  logic                          req_last_word,
   output logic                          rsp_strobe,
   output logic [31:0]                   rsp_result_word,
   output logic                          rsp_result_last,
   output logic                          rsp_too_long,
   input  logic                          csr_write_enable,
   input  logic [mxt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_write_data
);
   import mxt_pkg::*;

   key_type           key_ff;
   logic              mode_ff;
   dp_ctrl_type       ctrl;
   ram_wr_type        ram_wr;
   logic [WORD_W-1:0] ram_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY0: key_ff[0] <= csr_write_data;
            CSR_KEY1: key_ff[1] <= csr_write_data;
            CSR_KEY2: key_ff[2] <= csr_write_data;
            CSR_KEY3: key_ff[3] <= csr_write_data;
            CSR_MODE: mode_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   mxt_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .last_word    (req_last_word),
      .decrypt_mode (mode_ff),
      .key          (key_ff),
      .busy         (busy),
      .ctrl         (ctrl),
      .rsp_valid    (rsp_strobe),
      .rsp_last     (rsp_result_last),
      .rsp_over     (rsp_too_long)
   );

   // word update datapath
   mxt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .load_data (req_data_word),
      .rd_data   (ram_rd_data),
      .wr        (ram_wr)
   );

   // word store
   mxt_word_ram u_word_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (ctrl.rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_result_word = ram_rd_data;

endmodule

`default_nettype wire

// ===== tb/sv/modified_xxtea_block_cipher_checker.sv =====
// Checker for the modified XXTEA block cipher: predicts every result word of a block.
// Watches the request, result and register ports; depends on mxt_pkg only.
module modified_xxtea_block_cipher_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [31:0]                   req_data_word,
   input  logic                          req_last_word,
   input  logic                          rsp_strobe,
   input  logic [31:0]                   rsp_result_word,
   input  logic                          rsp_result_last,
   input  logic                          rsp_too_long,
   input  logic                          csr_write_enable,
   input  logic [mxt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_write_data,
   output int                            fail_count,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import mxt_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              too_long;
   } cipher_word_type;

   // shadow of the key, the mode and the block being collected
   key_type           cipher_key;
   logic              decrypt_mode;
   logic [WORD_W-1:0] block_words [MAX_WORDS];
   int                words_held;
   logic              words_dropped;

   // words of finished blocks not yet seen on the result port
   cipher_word_type   ciphered_words [$];
   cipher_word_type   oldest;
   int                slot;
   int                errors = 0;

   // mixing function with the 7/3/5/6 shifts
   function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] y, z, sum, k);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      a = (z >> 7) ^ (y << 3);
      b = (y >> 5) ^ (z << 6);
      c = (sum ^ y) + (k ^ z);
      return (a + b) ^ c;
   endfunction

   // in-place cipher over the first n words, n of at least two
   task automatic run_cipher(input int n);
      int                rounds;
      int                r;
      int                q;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [1:0]        kidx;
      rounds = (ROUND_BASE + ROUND_NUM / n) * n;
      if (!decrypt_mode) begin
         sum = '0;
         z = block_words[n-1];
         for (r = 0; r < rounds; r++) begin
            sum += TEA_DELTA;
            kidx = 2'(r) ^ sum[3:2];
            for (q = 0; q < n - 1; q++) begin
               y = block_words[q+1];
               block_words[q] += mix(y, z, sum, cipher_key[kidx]);
               z = block_words[q];
            end
            y = block_words[0];
            block_words[n-1] += mix(y, z, sum, cipher_key[kidx]);
            z = block_words[n-1];
         end
      end else begin
         // mirrored round number in the key index so this undoes encryption
         sum = TEA_DELTA * 32'(rounds);
         y = block_words[0];
         for (r = rounds - 1; r >= 0; r--) begin
            kidx = 2'(r) ^ sum[3:2];
            for (q = n - 1; q > 0; q--) begin
               z = block_words[q-1];
               block_words[q] -= mix(y, z, sum, cipher_key[kidx]);
               y = block_words[q];
            end
            z = block_words[n-1];
            block_words[0] -= mix(y, z, sum, cipher_key[kidx]);
            y = block_words[0];
            sum -= TEA_DELTA;
         end
      end
   endtask

   function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cipher_key = '0;
         decrypt_mode = 1'b0;
         words_held = 0;
         words_dropped = 1'b0;
         ciphered_words.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KEY0: cipher_key[0] = csr_write_data;
               CSR_KEY1: cipher_key[1] = csr_write_data;
               CSR_KEY2: cipher_key[2] = csr_write_data;
               CSR_KEY3: cipher_key[3] = csr_write_data;
               CSR_MODE: decrypt_mode = csr_write_data[0];
               default: ;
            endcase
         end

         // result against the oldest predicted word
         if (rsp_strobe) begin
            if (ciphered_words.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h last %b too_long %b",
                        $time, rsp_result_word, rsp_result_last, rsp_too_long);
               errors++;
            end else begin
               oldest = ciphered_words.pop_front();
               check_field("result_word", oldest.word, rsp_result_word);
               check_field("result_last", oldest.last, rsp_result_last);
               check_field("too_long", oldest.too_long, rsp_too_long);
            end
         end

         // accepted request: store or drop, cipher the block on its last word
         if (start && !busy) begin
            if (words_held < MAX_WORDS) begin
               block_words[words_held] = req_data_word;
               words_held++;
            end else begin
               words_dropped = 1'b1;
            end
            if (req_last_word) begin
               if (words_held >= 2) run_cipher(words_held);
               for (slot = 0; slot < words_held; slot++) begin
                  ciphered_words.push_back(cipher_word_type'{
                     word:     block_words[slot],
                     last:     slot == words_held - 1,
                     too_long: words_dropped});
               end
               words_held = 0;
               words_dropped = 1'b0;
            end
         end
      end
      fail_count <= errors;
      outstanding <= ciphered_words.size();
   end

endmodule

// ===== tb/sv/modified_xxtea_block_cipher_tb.sv =====
// Testbench top for the modified XXTEA block cipher: clock, reset, stimulus and verdict.
// Depends on mxt_pkg, the block itself and modified_xxtea_block_cipher_checker.
module modified_xxtea_block_cipher_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mxt_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int STALL_LIMIT   = 100000;
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES   = 50;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 14;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [31:0]          req_data_word = '0;
   logic                 req_last_word = 1'b0;
   logic                 rsp_strobe;
   logic [31:0]          rsp_result_word;
   logic                 rsp_result_last;
   logic                 rsp_too_long;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_write_data = '0;
   int                   fail_count;
   int                   outstanding;
   bit                   gaps_on = 1'b1;

   modified_xxtea_block_cipher u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_word    (req_data_word),
      .req_last_word    (req_last_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_word  (rsp_result_word),
      .rsp_result_last  (rsp_result_last),
      .rsp_too_long     (rsp_too_long),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   modified_xxtea_block_cipher_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_word    (req_data_word),
      .req_last_word    (req_last_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_word  (rsp_result_word),
      .rsp_result_last  (rsp_result_last),
      .rsp_too_long     (rsp_too_long),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // watchdog on cycles with no request and no result
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end
      $display("modified_xxtea_block_cipher verification failed");
      $finish;
   end

   // drop start, let the last request land, wait until the block is idle and
   // every predicted word is out, then the requested number of quiet cycles
   task automatic settle(input int cycles);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   // key and mode, written only with the block idle
   task automatic load_cipher(input key_type key, input logic mode);
      settle(SETTLE_CYCLES);
      write_reg(CSR_KEY0, key[0]);
      write_reg(CSR_KEY1, key[1]);
      write_reg(CSR_KEY2, key[2]);
      write_reg(CSR_KEY3, key[3]);
      write_reg(CSR_MODE, {31'b0, mode});
      csr_write_enable <= 1'b0;
   endtask

   // one request, held until the block takes it
   task automatic send_word(input logic [31:0] word, input logic last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_data_word <= word;
      req_last_word <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_block(input int n, input fill_kind_type fill);
      int          i;
      logic [31:0] word;
      for (i = 0; i < n; i++) begin
         case (fill)
            FILL_ZERO: word = '0;
            FILL_ONES: word = '1;
            default:   word = $urandom();
         endcase
         send_word(word, i == n - 1);
      end
   endtask

   initial begin
      key_type phase_key;
      int      ph;
      int      sent;
      int      n;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero key, encrypt: one-word blocks pass through, short blocks at the extremes
      load_cipher('0, 1'b0);
      send_block(1, FILL_ZERO);
      send_block(1, FILL_ONES);
      send_block(2, FILL_ZERO);
      send_block(2, FILL_ONES);
      send_block(3, FILL_RANDOM);

      // all-ones key, decrypt
      load_cipher('1, 1'b1);
      send_block(1, FILL_RANDOM);
      send_block(2, FILL_ONES);
      send_block(5, FILL_RANDOM);

      // full store and overflow, the last word among the dropped ones
      phase_key = {$urandom(), $urandom(), $urandom(), $urandom()};
      load_cipher(phase_key, 1'b0);
      send_block(MAX_WORDS + 2, FILL_RANDOM);
      load_cipher(phase_key, 1'b1);
      send_block(2, FILL_RANDOM);

      // random keys, alternating mode, mostly short blocks; no gaps in the last phase
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         phase_key = {$urandom(), $urandom(), $urandom(), $urandom()};
         load_cipher(phase_key, 1'(ph % 2));
         gaps_on = (ph < RANDOM_PHASES - 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            send_block(n, FILL_RANDOM);
            sent += n;
         end
      end

      settle(TAIL_CYCLES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("modified_xxtea_block_cipher verification clean");
      end else begin
         $display("modified_xxtea_block_cipher verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mxt_pkg.sv
hdl/mxt_word_ram.sv
hdl/mxt_datapath.sv
hdl/mxt_seq.sv
hdl/modified_xxtea_block_cipher.sv
tb/sv/modified_xxtea_block_cipher_checker.sv
tb/sv/modified_xxtea_block_cipher_tb.sv
